### sv/pvar_pkg.sv
// Package for the population variance core: widths, types and structs.
// Depends on nothing; used by every module of the block.
`default_nettype none

package pvar_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_SAMPLES = 65535;
    localparam int FRAC_BITS   = 8;

    localparam int IN_W        = 16;
    localparam int COUNT_OUT_W = 16;
    localparam int VAR_W       = 38;

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = SAMPLE_BITS + CNT_W;
    localparam int SQ_W  = 2 * SAMPLE_BITS + CNT_W;
    localparam int NUM_W = 2 * SUM_W;
    localparam int DEN_W = 2 * CNT_W;
    localparam int DIV_W = NUM_W + FRAC_BITS;
    localparam int ALU_W = NUM_W;
    localparam int CTR_W = $clog2(DIV_W);
    localparam int CMP_W = (DIV_W > VAR_W) ? DIV_W : VAR_W;

    typedef logic [SAMPLE_BITS-1:0]        smp_t;
    typedef logic [2*SAMPLE_BITS-1:0]      sqp_t;
    typedef logic [CNT_W-1:0]              cnt_t;
    typedef logic signed [SUM_W-1:0]       sum_t;
    typedef logic [SUM_W-1:0]              mag_t;
    typedef logic [SQ_W-1:0]               sq_t;
    typedef logic [NUM_W-1:0]              num_t;
    typedef logic [DEN_W-1:0]              den_t;
    typedef logic [DEN_W:0]                trial_t;
    typedef logic [DIV_W-1:0]              quo_t;
    typedef logic [CMP_W-1:0]              cmp_t;
    typedef logic [CTR_W-1:0]              ctr_t;
    typedef logic [VAR_W-1:0]              var_t;
    typedef logic [COUNT_OUT_W-1:0]        cout_t;

    localparam var_t VAR_MAX = '1;

    // Accumulator contents seen by the finishing sequencer and the top level
    typedef struct packed {
        cnt_t             count;
        logic signed [SUM_W-1:0] sum;
        sq_t              square;
        logic             ovf;
    } acc_t;

    // Request to and response from the shared adder
    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } alu_req_t;

    typedef struct packed {
        logic [ALU_W-1:0] sum;
        logic             carry;
    } alu_rsp_t;

    // Sequencer status toward the top level
    typedef struct packed {
        logic idle;
        logic done;
        var_t variance;
    } seq_stat_t;

endpackage

`default_nettype wire

### sv/population_variance_core.sv
// Top level of the population variance core: handshakes, result register.
// Depends on pvar_pkg, pvar_accum, pvar_alu and pvar_seq.
//
//  channel  | valid / ready               | payload
//  ---------+-----------------------------+----------------------------------
//  item     | item_valid / item_ready     | sample[15:0] signed, last
//  result   | result_valid / result_ready | sample_count[15:0],
//           |                             | variance_q8[37:0], overflowed
//
// An item without last needs no further work: the square is formed by one
// small multiplier and folded into the accumulators as the item is accepted.
// An item with last starts the finishing sequence on the shared adder:
// load, n * sum of squares, sum squared, subtract, n * n, restoring
// division, done and handoff to the result register; item_ready stays
// low meanwhile. The result register frees the sequencer once it loads, so
// new items flow while a result waits to be taken.
// Reset clears the accumulators, the sequencer and result_valid.
`default_nettype none

module population_variance_core (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                item_valid,
    output logic                               item_ready,
    input  wire [pvar_pkg::IN_W-1:0]           sample,
    input  wire                                last,
    output logic                               result_valid,
    input  wire                                result_ready,
    output logic [pvar_pkg::COUNT_OUT_W-1:0]   sample_count,
    output logic [pvar_pkg::VAR_W-1:0]         variance_q8,
    output logic                               overflowed
);

    pvar_pkg::acc_t       acc;
    pvar_pkg::alu_req_t   alu_req;
    pvar_pkg::alu_rsp_t   alu_rsp;
    pvar_pkg::seq_stat_t  stat;

    logic accept;
    logic start;
    logic load_out;

    logic                  result_valid_reg, result_valid_next;
    pvar_pkg::cout_t       sample_count_reg;
    pvar_pkg::var_t        variance_q8_reg;
    logic                  overflowed_reg;

    // Take items only while the sequencer is idle
    assign item_ready = stat.idle;
    assign accept     = item_valid & item_ready;
    assign start      = accept & last;

    // Hand the finished result over when the result register is free or
    // drains this cycle; the same edge clears the accumulators
    assign load_out = stat.done & (~result_valid_reg | result_ready);

    pvar_accum u_accum (
        .clk    (clk),
        .rst_n  (rst_n),
        .upd    (accept),
        .clr    (load_out),
        .sample (sample),
        .acc    (acc)
    );

    pvar_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    pvar_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .ack     (load_out),
        .acc     (acc),
        .alu_rsp (alu_rsp),
        .alu_req (alu_req),
        .stat    (stat)
    );

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (load_out)
            result_valid_next = 1'b1;
        else if (result_ready)
            result_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= result_valid_next;
    end

    // Result payload: hold until the next load
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            sample_count_reg <= pvar_pkg::cout_t'(acc.count);
            variance_q8_reg  <= stat.variance;
            overflowed_reg   <= acc.ovf;
        end
    end

    assign result_valid = result_valid_reg;
    assign sample_count = sample_count_reg;
    assign variance_q8  = variance_q8_reg;
    assign overflowed   = overflowed_reg;

endmodule

`default_nettype wire

### sv/pvar_alu.sv
// Shared add/subtract unit of the variance core.
// Depends on pvar_pkg; driven by pvar_seq.
`default_nettype none

module pvar_alu (
    input  wire pvar_pkg::alu_req_t req,
    output pvar_pkg::alu_rsp_t      rsp
);

    logic [pvar_pkg::ALU_W:0] total;

    // carry high on subtract means no borrow (a >= b)
    assign total = {1'b0, req.a}
                 + {1'b0, req.b ^ {pvar_pkg::ALU_W{req.sub}}}
                 + {{pvar_pkg::ALU_W{1'b0}}, req.sub};

    assign rsp.sum   = total[pvar_pkg::ALU_W-1:0];
    assign rsp.carry = total[pvar_pkg::ALU_W];

endmodule

`default_nettype wire

### sv/pvar_accum.sv
// Sample accumulators: count, signed sum, sum of squares, overflow flag.
// Depends on pvar_pkg.
`default_nettype none

module pvar_accum (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         upd,
    input  wire                         clr,
    input  wire [pvar_pkg::IN_W-1:0]    sample,
    output pvar_pkg::acc_t              acc
);

    pvar_pkg::smp_t v;
    pvar_pkg::smp_t mag;
    pvar_pkg::sqp_t sq;

    pvar_pkg::cnt_t count_reg, count_next;
    pvar_pkg::sum_t sum_reg, sum_next;
    pvar_pkg::sq_t  square_reg, square_next;
    logic           ovf_reg, ovf_next;

    always_comb
    begin
        v   = pvar_pkg::smp_t'(sample);
        mag = v[pvar_pkg::SAMPLE_BITS-1] ? (~v + pvar_pkg::smp_t'(1)) : v;
        sq  = pvar_pkg::sqp_t'(mag) * pvar_pkg::sqp_t'(mag);

        count_next  = count_reg;
        sum_next    = sum_reg;
        square_next = square_reg;
        ovf_next    = ovf_reg;
        if (clr)
        begin
            count_next  = '0;
            sum_next    = '0;
            square_next = '0;
            ovf_next    = 1'b0;
        end
        else if (upd)
        begin
            if (count_reg < pvar_pkg::cnt_t'(pvar_pkg::MAX_SAMPLES))
            begin
                count_next  = count_reg + pvar_pkg::cnt_t'(1);
                sum_next    = sum_reg + pvar_pkg::sum_t'($signed(v));
                square_next = square_reg + pvar_pkg::sq_t'(sq);
            end
            else
            begin
                // drop the sample, flag the set
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            sum_reg    <= '0;
            square_reg <= '0;
            ovf_reg    <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            sum_reg    <= sum_next;
            square_reg <= square_next;
            ovf_reg    <= ovf_next;
        end
    end

    assign acc.count  = count_reg;
    assign acc.sum    = sum_reg;
    assign acc.square = square_reg;
    assign acc.ovf    = ovf_reg;

endmodule

`default_nettype wire

### sv/pvar_seq.sv
// Finishing sequencer: shift-add products and restoring division on the
// shared adder. Depends on pvar_pkg; uses pvar_alu through alu_req/alu_rsp.
`default_nettype none

module pvar_seq (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       start,
    input  wire                       ack,
    input  wire pvar_pkg::acc_t       acc,
    input  wire pvar_pkg::alu_rsp_t   alu_rsp,
    output pvar_pkg::alu_req_t        alu_req,
    output pvar_pkg::seq_stat_t       stat
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL_NS,
        ST_MUL_SS,
        ST_SUB,
        ST_MUL_NN,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t             state_reg, state_next;
    pvar_pkg::ctr_t     ctr_reg, ctr_next;
    pvar_pkg::mag_t     mplr_reg, mplr_next;
    pvar_pkg::num_t     p_reg, p_next;
    pvar_pkg::num_t     q_reg, q_next;
    pvar_pkg::quo_t     work_reg, work_next;
    pvar_pkg::den_t     rem_reg, rem_next;
    pvar_pkg::var_t     var_reg, var_next;

    pvar_pkg::mag_t     sum_bits;
    pvar_pkg::mag_t     sum_mag;
    pvar_pkg::mag_t     count_msb;
    pvar_pkg::trial_t   trial;
    logic               mbit;
    logic               qbit;

    always_comb
    begin
        sum_bits  = pvar_pkg::mag_t'(acc.sum);
        sum_mag   = sum_bits[pvar_pkg::SUM_W-1] ? (~sum_bits + pvar_pkg::mag_t'(1))
                                                : sum_bits;
        // count aligned to the top of the multiplier shift register
        count_msb = pvar_pkg::mag_t'(acc.count) << pvar_pkg::SAMPLE_BITS;
        mbit      = mplr_reg[pvar_pkg::SUM_W-1];
        trial     = {rem_reg, work_reg[pvar_pkg::DIV_W-1]};
        qbit      = 1'b0;

        state_next = state_reg;
        ctr_next   = ctr_reg;
        mplr_next  = mplr_reg;
        p_next     = p_reg;
        q_next     = q_reg;
        work_next  = work_reg;
        rem_next   = rem_reg;
        var_next   = var_reg;
        alu_req    = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                p_next     = '0;
                mplr_next  = count_msb;
                ctr_next   = pvar_pkg::ctr_t'(pvar_pkg::CNT_W - 1);
                state_next = ST_MUL_NS;
            end
            ST_MUL_NS:
            begin
                // n * sum of squares, multiplier bit MSB first
                alu_req.a = {p_reg[pvar_pkg::NUM_W-2:0], 1'b0};
                alu_req.b = mbit ? pvar_pkg::num_t'(acc.square) : '0;
                p_next    = alu_rsp.sum;
                mplr_next = {mplr_reg[pvar_pkg::SUM_W-2:0], 1'b0};
                ctr_next  = ctr_reg - pvar_pkg::ctr_t'(1);
                if (ctr_reg == '0)
                begin
                    q_next     = '0;
                    mplr_next  = sum_mag;
                    ctr_next   = pvar_pkg::ctr_t'(pvar_pkg::SUM_W - 1);
                    state_next = ST_MUL_SS;
                end
            end
            ST_MUL_SS:
            begin
                // sum squared
                alu_req.a = {q_reg[pvar_pkg::NUM_W-2:0], 1'b0};
                alu_req.b = mbit ? pvar_pkg::num_t'(sum_mag) : '0;
                q_next    = alu_rsp.sum;
                mplr_next = {mplr_reg[pvar_pkg::SUM_W-2:0], 1'b0};
                ctr_next  = ctr_reg - pvar_pkg::ctr_t'(1);
                if (ctr_reg == '0)
                    state_next = ST_SUB;
            end
            ST_SUB:
            begin
                alu_req.a   = p_reg;
                alu_req.b   = q_reg;
                alu_req.sub = 1'b1;
                p_next      = alu_rsp.sum;
                work_next   = pvar_pkg::quo_t'(alu_rsp.sum) << pvar_pkg::FRAC_BITS;
                q_next      = '0;
                mplr_next   = count_msb;
                ctr_next    = pvar_pkg::ctr_t'(pvar_pkg::CNT_W - 1);
                state_next  = ST_MUL_NN;
            end
            ST_MUL_NN:
            begin
                // denominator n * n
                alu_req.a = {q_reg[pvar_pkg::NUM_W-2:0], 1'b0};
                alu_req.b = mbit ? pvar_pkg::num_t'(acc.count) : '0;
                q_next    = alu_rsp.sum;
                mplr_next = {mplr_reg[pvar_pkg::SUM_W-2:0], 1'b0};
                ctr_next  = ctr_reg - pvar_pkg::ctr_t'(1);
                if (ctr_reg == '0)
                begin
                    rem_next   = '0;
                    ctr_next   = pvar_pkg::ctr_t'(pvar_pkg::DIV_W - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // restoring division, one quotient bit per cycle
                alu_req.a   = pvar_pkg::num_t'(trial);
                alu_req.b   = q_reg;
                alu_req.sub = 1'b1;
                if (alu_rsp.carry)
                begin
                    qbit     = 1'b1;
                    rem_next = alu_rsp.sum[pvar_pkg::DEN_W-1:0];
                end
                else
                begin
                    rem_next = trial[pvar_pkg::DEN_W-1:0];
                end
                work_next = {work_reg[pvar_pkg::DIV_W-2:0], qbit};
                ctr_next  = ctr_reg - pvar_pkg::ctr_t'(1);
                if (ctr_reg == '0)
                begin
                    if (acc.count == '0)
                        var_next = '0;
                    else if (pvar_pkg::cmp_t'(work_next) > pvar_pkg::cmp_t'(pvar_pkg::VAR_MAX))
                        var_next = pvar_pkg::VAR_MAX;
                    else
                        var_next = pvar_pkg::var_t'(work_next);
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (ack)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ctr_reg   <= '0;
            mplr_reg  <= '0;
            p_reg     <= '0;
            q_reg     <= '0;
            work_reg  <= '0;
            rem_reg   <= '0;
            var_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ctr_reg   <= ctr_next;
            mplr_reg  <= mplr_next;
            p_reg     <= p_next;
            q_reg     <= q_next;
            work_reg  <= work_next;
            rem_reg   <= rem_next;
            var_reg   <= var_next;
        end
    end

    assign stat.idle     = (state_reg == ST_IDLE);
    assign stat.done     = (state_reg == ST_DONE);
    assign stat.variance = var_reg;

endmodule

`default_nettype wire

### dv/population_variance_checker.sv
// Checker for population_variance_core: watches both channels, predicts each
// result from the accepted items and compares field by field.
// Depends on pvar_pkg for widths and types.
`default_nettype none

module population_variance_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    input  logic                              item_ready,
    input  logic [pvar_pkg::IN_W-1:0]         sample,
    input  logic                              last,
    input  logic                              result_valid,
    input  logic                              result_ready,
    input  logic [pvar_pkg::COUNT_OUT_W-1:0]  sample_count,
    input  logic [pvar_pkg::VAR_W-1:0]        variance_q8,
    input  logic                              overflowed,
    output int                                mismatches,
    output int                                outstanding,
    output int                                sets_checked,
    output int                                dropped_sets
);
    timeunit 1ns;
    timeprecision 1ps;

    import pvar_pkg::*;

    localparam int EXT = IN_W - SAMPLE_BITS;

    typedef struct {
        cout_t count;
        var_t  variance;
        logic  dropped;
    } set_result_t;

    // Running statistics of the set in progress
    logic [CNT_W:0] n_taken;
    sum_t           running_sum;
    sq_t            running_squares;
    logic           dropped;

    set_result_t expected_results[$];
    int          fail_total;
    int          checked_total;
    int          dropped_total;

    // (n*S2 - S1^2) << FRAC_BITS, divided by n^2, truncated and saturated
    function automatic var_t variance_q8_of(input logic [CNT_W:0] n, input sum_t total,
                                            input sq_t squares);
        logic [127:0] wide_n;
        logic [127:0] magnitude;
        logic [127:0] numer;
        logic [127:0] quot;
        if (n == 0)
            return '0;
        wide_n    = n;
        magnitude = total[SUM_W-1] ? mag_t'(-total) : mag_t'(total);
        numer     = (wide_n * squares - magnitude * magnitude) << FRAC_BITS;
        quot      = numer / (wide_n * wide_n);
        if (quot > VAR_MAX)
            return VAR_MAX;
        return quot[VAR_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        logic signed [IN_W-1:0] value;
        longint                 wide_value;
        set_result_t            want;
        if (!rst_n) begin
            n_taken         = '0;
            running_sum     = '0;
            running_squares = '0;
            dropped         = 1'b0;
            fail_total      = 0;
            checked_total   = 0;
            dropped_total   = 0;
            expected_results.delete();
            mismatches   <= 0;
            outstanding  <= 0;
            sets_checked <= 0;
            dropped_sets <= 0;
        end
        else begin
            // Results first: a result at this edge never belongs to an item
            // accepted at the same edge.
            if (result_valid && result_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected: count %0d variance %0d ovf %0b",
                           sample_count, variance_q8, overflowed);
                    fail_total++;
                end
                else begin
                    want = expected_results.pop_front();
                    checked_total++;
                    if (sample_count !== want.count) begin
                        $error("sample_count: expected %0d, got %0d",
                               want.count, sample_count);
                        fail_total++;
                    end
                    if (variance_q8 !== want.variance) begin
                        $error("variance_q8: expected %0d, got %0d",
                               want.variance, variance_q8);
                        fail_total++;
                    end
                    if (overflowed !== want.dropped) begin
                        $error("overflowed: expected %0b, got %0b",
                               want.dropped, overflowed);
                        fail_total++;
                    end
                end
            end

            if (item_valid && item_ready) begin
                value      = $signed(sample << EXT) >>> EXT;
                wide_value = value;
                if (n_taken < MAX_SAMPLES) begin
                    n_taken         = n_taken + 1'b1;
                    running_sum     = running_sum + sum_t'(wide_value);
                    running_squares = running_squares + sq_t'(wide_value * wide_value);
                end
                else begin
                    dropped = 1'b1;
                end
                if (last) begin
                    want.count    = cout_t'(n_taken);
                    want.variance = variance_q8_of(n_taken, running_sum, running_squares);
                    want.dropped  = dropped;
                    if (dropped)
                        dropped_total++;
                    expected_results.push_back(want);
                    n_taken         = '0;
                    running_sum     = '0;
                    running_squares = '0;
                    dropped         = 1'b0;
                end
            end

            mismatches   <= fail_total;
            outstanding  <= expected_results.size();
            sets_checked <= checked_total;
            dropped_sets <= dropped_total;
        end
    end

endmodule

`default_nettype wire

### dv/population_variance_core_tb.sv
// Testbench top for population_variance_core: clock, reset, sample stimulus,
// result back-pressure, watchdog and verdict. Depends on pvar_pkg, the core
// and population_variance_checker.
`default_nettype none

module population_variance_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pvar_pkg::*;

    // Random part size, quiet cycles allowed before giving up, and the drain
    // time after the last result (one full finishing sequence plus margin).
    localparam int RANDOM_ITEMS = 800;
    localparam int STALL_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 300;

    localparam logic [IN_W-1:0] MOST_NEG = 16'h8000;
    localparam logic [IN_W-1:0] MOST_POS = 16'h7FFF;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                   item_valid   = 1'b0;
    logic                   item_ready;
    logic [IN_W-1:0]        sample       = '0;
    logic                   last         = 1'b0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    logic [COUNT_OUT_W-1:0] sample_count;
    logic [VAR_W-1:0]       variance_q8;
    logic                   overflowed;

    int mismatches;
    int outstanding;
    int sets_checked;
    int dropped_sets;

    // Receiver behavior: when ready_stalls is low, take every result at once
    logic ready_stalls = 1'b0;
    int   stall_left;
    int   quiet_cycles;
    int   items_sent;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    population_variance_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .sample       (sample),
        .last         (last),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .sample_count (sample_count),
        .variance_q8  (variance_q8),
        .overflowed   (overflowed)
    );

    population_variance_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .sample       (sample),
        .last         (last),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .sample_count (sample_count),
        .variance_q8  (variance_q8),
        .overflowed   (overflowed),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .sets_checked (sets_checked),
        .dropped_sets (dropped_sets)
    );

    // Result back-pressure: mostly short random stalls, now and then a long
    // one so that a finished result sits in the output register while the
    // next set streams in.
    always @(posedge clk or negedge rst_n) begin : result_sink
        int pick;
        if (!rst_n) begin
            result_ready <= 1'b0;
            stall_left   <= 0;
        end
        else if (stall_left != 0) begin
            result_ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else if (!ready_stalls) begin
            result_ready <= 1'b1;
        end
        else begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                result_ready <= 1'b0;
                stall_left   <= $urandom_range(10, 40);
            end
            else if (pick < 35) begin
                result_ready <= 1'b0;
                stall_left   <= $urandom_range(0, 2);
            end
            else begin
                result_ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if neither channel moves for too long
    always @(posedge clk) begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("population_variance_core_tb: done, errors");
            $finish;
        end
    end

    // Gap before an item: usually none or a few cycles, rarely a long one so
    // that idle time also lands on the finishing sequence.
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 85)
            return $urandom_range(1, 3);
        if (p < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    // Sample values: full range most of the time, plus small values (tiny
    // variances, truncation) and the extremes of the field.
    function automatic logic [IN_W-1:0] pick_sample();
        int p;
        p = $urandom_range(0, 99);
        if (p < 10) begin
            case ($urandom_range(0, 3))
                0:       return MOST_NEG;
                1:       return MOST_POS;
                2:       return '0;
                default: return '1;
            endcase
        end
        if (p < 40)
            return IN_W'($urandom_range(0, 16) - 8);
        return IN_W'($urandom());
    endfunction

    // Set length: mostly short sets, some medium, a few long
    function automatic int pick_set_length();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70)
            return $urandom_range(1, 6);
        if (p < 95)
            return $urandom_range(7, 40);
        return $urandom_range(41, 200);
    endfunction

    // Present one item after an optional gap; hold it until it is taken.
    // Lower valid only during the gap so that valid is assigned at most once
    // per edge.
    task automatic send_item(input logic [IN_W-1:0] value, input logic is_last,
                             input int gap);
        repeat (gap) begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        sample     <= value;
        last       <= is_last;
        do
            @(posedge clk);
        while (!item_ready);
        items_sent++;
    endtask

    // Hold the sender until every predicted result has been taken
    task automatic wait_for_results();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    initial begin : stimulus
        int  set_len;
        int  random_sent;
        logic idle_on;

        items_sent = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed sets: single samples, extreme spread, constant sets,
        // smallest nonzero variance and a truncated fraction.
        ready_stalls <= 1'b1;
        send_item('0, 1'b1, pick_gap());
        send_item(MOST_NEG, 1'b1, pick_gap());
        send_item(MOST_POS, 1'b1, pick_gap());
        send_item(MOST_NEG, 1'b0, pick_gap());
        send_item(MOST_POS, 1'b1, pick_gap());
        send_item(MOST_POS, 1'b0, pick_gap());
        send_item(MOST_POS, 1'b0, pick_gap());
        send_item(MOST_POS, 1'b1, pick_gap());
        send_item(16'h0001, 1'b0, pick_gap());
        send_item('1, 1'b1, pick_gap());
        send_item('0, 1'b0, pick_gap());
        send_item(16'h0001, 1'b0, pick_gap());
        send_item(16'h0002, 1'b1, pick_gap());
        send_item(16'h5555, 1'b0, pick_gap());
        send_item(16'hAAAA, 1'b0, pick_gap());
        send_item('1, 1'b0, pick_gap());
        send_item(16'hFFFE, 1'b1, pick_gap());
        wait_for_results();

        // Random sets; each picks whether the sender idles and whether the
        // receiver stalls, and now and then the sender drains the core.
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            set_len      = pick_set_length();
            idle_on      = ($urandom_range(0, 3) != 0);
            ready_stalls <= ($urandom_range(0, 3) != 0);
            for (int k = 0; k < set_len; k++) begin
                send_item(pick_sample(), k == set_len - 1, idle_on ? pick_gap() : 0);
                random_sent++;
            end
            if ($urandom_range(0, 19) == 0)
                wait_for_results();
        end

        // Drain, then give the core time to emit anything it should not
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d items in %0d checked sets, %0d of them past the %0d-sample cap",
                 items_sent, sets_checked, dropped_sets, MAX_SAMPLES);
        $display("sets ran from one to 200 samples, with random gaps and result stalls");
        if (mismatches == 0)
            $display("population_variance_core_tb: done, clean");
        else
            $display("population_variance_core_tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
sv/pvar_pkg.sv
sv/pvar_alu.sv
sv/pvar_accum.sv
sv/pvar_seq.sv
sv/population_variance_core.sv
dv/population_variance_checker.sv
dv/population_variance_core_tb.sv
